// ===== hdl/spwm_pkg.sv =====
// shared types and constants for the three-channel servo pulse unit
package spwm_pkg;

	localparam int SAMPLE_W = 12;
	localparam int WIDTH_W = 11;
	localparam int PERIOD_W = 16;
	localparam int CH_W = 2;
	localparam int QUO_W = 9;
	localparam int MUL_W = 30;
	localparam int PROD_W = SAMPLE_W + MUL_W;
	localparam int RECIP_SHIFT = 31;

	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 16;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// register index taken from paddr[2]
	localparam logic REG_PERIOD = 1'b0;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd20000;

	localparam logic [SAMPLE_W-1:0] DEAD_LOW = 12'd1948;
	localparam logic [SAMPLE_W-1:0] DEAD_HIGH = 12'd2147;
	localparam logic [WIDTH_W-1:0] WIDTH_MIN = 11'd1000;
	localparam logic [WIDTH_W-1:0] WIDTH_MID = 11'd1500;
	localparam logic [WIDTH_W-1:0] WIDTH_MAX = 11'd2000;

	// 500 * ceil(2^31 / 1947) and 500 * ceil(2^31 / 1948): exact floor for these ranges
	localparam logic [MUL_W-1:0] LO_MUL = 30'd551485500;
	localparam logic [MUL_W-1:0] HI_MUL = 30'd551202500;

	typedef logic [WIDTH_W-1:0] width_t;

endpackage

// ===== hdl/spwm_map.sv =====
// potentiometer sample to pulse width map with center deadband
module spwm_map import spwm_pkg::*; (
	input  logic [SAMPLE_W-1:0] sample,
	output width_t              width
);

	logic                is_lo;
	logic                is_hi;
	logic [SAMPLE_W-1:0] op;
	logic [MUL_W-1:0]    recip;
	logic [PROD_W-1:0]   prod;
	logic [QUO_W-1:0]    quo;
	width_t              base;

	always_comb begin
		is_lo = sample < DEAD_LOW;
		is_hi = sample >= DEAD_HIGH;
		// one shared constant multiply, operand and reciprocal picked by side
		op    = is_lo ? sample : (sample - DEAD_HIGH);
		recip = is_lo ? LO_MUL : HI_MUL;
		prod  = PROD_W'(op) * PROD_W'(recip);
		quo   = prod[RECIP_SHIFT +: QUO_W];
		base  = is_lo ? WIDTH_MIN : WIDTH_MID;
		if (is_lo || is_hi) begin
			width = base + WIDTH_W'(quo);
		end else begin
			width = WIDTH_MID;
		end
	end

endmodule

// ===== hdl/three_channel_servo_pwm_deadband_unit.sv =====
// three-channel servo pulse generator with deadband: top level
// Each input beat is a one-microsecond tick or a potentiometer sample and yields one output beat
// carrying the pin levels and the addressed channel's pulse width. One beat is taken every
// clock cycle while s_tready is high; its result is registered in the output register, or in
// the skid entry when the output is stalled. The frame counter, widths and pin levels update
// at the accepting edge, so back-to-back beats see each other's effects. A two-entry output
// buffer keeps s_tready high while one stalled beat waits; s_tready drops only while both
// entries are full. The frame length is set through the APB register at byte address 0.
module three_channel_servo_pwm_deadband_unit import spwm_pkg::*; #(
	parameter int CHANNELS = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,  // channel[1:0], sample[13:2], zero[15:14]
	input  logic [0:0]            s_tuser,  // req_type[0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata   // level_a[0], level_b[1], level_c[2], width_now[13:3]
);

	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] count_q;
	width_t              width_q [CHANNELS];
	logic [CHANNELS-1:0] pins_q;

	logic [M_TDATA_W-1:0] out_data_q;
	logic                 out_valid_q;
	logic [M_TDATA_W-1:0] skid_data_q;
	logic                 skid_valid_q;

	logic                 req_type;
	logic [CH_W-1:0]      channel;
	logic [SAMPLE_W-1:0]  sample;
	logic                 ch_ok;
	logic                 accept;
	logic                 cfg_wr;
	width_t               mapped;

	logic [PERIOD_W-1:0]  count_inc;
	logic                 wrap;
	logic [PERIOD_W-1:0]  count_tick;
	logic [PERIOD_W-1:0]  count_nxt;
	logic [CHANNELS-1:0]  pins_tick;
	logic [CHANNELS-1:0]  pins_nxt;
	width_t               width_nxt [CHANNELS];
	width_t               width_sel;
	logic [7:0]           pins_wide;
	logic [M_TDATA_W-1:0] result;

	assign req_type = s_tuser[0];
	assign channel  = s_tdata[CH_W-1:0];
	assign sample   = s_tdata[CH_W +: SAMPLE_W];
	assign ch_ok    = 4'(channel) < 4'(CHANNELS);
	assign s_tready = !skid_valid_q;
	assign accept   = s_tvalid && s_tready;

	spwm_map u_map (
		.sample (sample),
		.width  (mapped)
	);

	always_comb begin
		count_inc  = count_q + 16'd1;
		wrap       = count_inc >= period_q;
		count_tick = wrap ? '0 : count_inc;
		pins_tick  = wrap ? '1 : pins_q;
		for (int n = 0; n < CHANNELS; n++) begin
			if (count_tick == PERIOD_W'(width_q[n])) begin
				pins_tick[n] = 1'b0;
			end
		end
		count_nxt = req_type ? count_q : count_tick;
		pins_nxt  = req_type ? pins_q : pins_tick;

		width_sel = '0;
		for (int n = 0; n < CHANNELS; n++) begin
			width_nxt[n] = width_q[n];
			if (req_type && 4'(channel) == 4'(n)) begin
				width_nxt[n] = mapped;
			end
			if (ch_ok && 4'(channel) == 4'(n)) begin
				width_sel = width_nxt[n];
			end
		end

		// missing channels read as low
		pins_wide = 8'(pins_nxt);
		result    = {2'b00, width_sel, pins_wide[2:0]};
	end

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_PERIOD) ? APB_DATA_W'(period_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (cfg_wr && paddr[2] == REG_PERIOD) begin
			period_q <= pwdata[PERIOD_W-1:0];
		end
	end

	// servo state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pins_q  <= '0;
			for (int n = 0; n < CHANNELS; n++) begin
				width_q[n] <= WIDTH_MID;
			end
		end else if (accept) begin
			count_q <= count_nxt;
			pins_q  <= pins_nxt;
			for (int n = 0; n < CHANNELS; n++) begin
				width_q[n] <= width_nxt[n];
			end
		end
	end

	// output register plus skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			out_data_q <= skid_valid_q ? skid_data_q : result;
		end else if (accept) begin
			skid_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== hdl/spwm_checker.sv =====
// port-level checks for the servo pulse unit, bound to the top level
module spwm_checker import spwm_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  psel,
	input logic                  penable,
	input logic                  pwrite,
	input logic                  pready,
	input logic [APB_ADDR_W-1:0] paddr,
	input logic [APB_DATA_W-1:0] pwdata,
	input logic [APB_DATA_W-1:0] prdata,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [M_TDATA_W-1:0]  m_tdata
);

	width_t w_out;
	assign w_out = m_tdata[3 +: WIDTH_W];

	// a stalled output beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	// width is zero for a bad channel, else within the servo range
	a_width: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (w_out == '0 || (w_out >= WIDTH_MIN && w_out <= WIDTH_MAX)))
		else $error("width_now out of range");

	// no output beat appears without an input beat or a waiting one
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(s_tvalid && s_tready) && !$past(m_tvalid) |-> !m_tvalid)
		else $error("output beat without input");

	// the period register reads back what was written
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[2] == REG_PERIOD
		|=> (paddr[2] != REG_PERIOD || prdata[PERIOD_W-1:0] == $past(pwdata[PERIOD_W-1:0])))
		else $error("period readback mismatch");

endmodule

bind three_channel_servo_pwm_deadband_unit spwm_checker u_spwm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.pready   (pready),
	.paddr    (paddr),
	.pwdata   (pwdata),
	.prdata   (prdata),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
